>>> hw/rtl/first_fit_page_allocator_compacting_macros.svh
// Assertion macros for the first-fit page allocator
`ifndef FIRST_FIT_PAGE_ALLOCATOR_COMPACTING_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_COMPACTING_MACROS_SVH

`define FFPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define FFPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ffpa_pkg.sv
// Types and constants shared by the page allocator modules
`timescale 1ns / 1ps
package ffpa_pkg;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  localparam logic [1:0] ST_FAIL = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_MOVE  = 1'b1;

  localparam logic [1:0] CFG_TOTAL_PAGES = 2'd0;
  localparam logic [1:0] CFG_PAGE_BYTES  = 2'd1;

  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_LATCH   = 4'd1;
  localparam logic [3:0] CMD_NEXT    = 4'd2;
  localparam logic [3:0] CMD_LOAD    = 4'd3;
  localparam logic [3:0] CMD_RW_UPD  = 4'd4;
  localparam logic [3:0] CMD_CLR     = 4'd5;
  localparam logic [3:0] CMD_SUM     = 4'd6;
  localparam logic [3:0] CMD_MOVE    = 4'd7;
  localparam logic [3:0] CMD_COMPACT = 4'd8;
  localparam logic [3:0] CMD_ALLOC   = 4'd9;
  localparam logic [3:0] CMD_MUL     = 4'd10;
  localparam logic [3:0] CMD_REPLY   = 4'd11;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] pid;
    logic [12:0] page_or_count;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] reply_pid;
    logic [27:0] byte_address;
    logic [12:0] old_start_page;
    logic [12:0] new_start_page;
    logic [12:0] move_pages;
    logic [15:0] read_count;
    logic [15:0] write_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       proc_end;
    logic       hole_end;
    logic       proc_full;
    logic       arg_zero;
    logic       pid_hit;
    logic       page_ok;
    logic       hole_fit;
    logic       space_ok;
  } stat_t;

endpackage

>>> hw/rtl/first_fit_page_allocator_compacting.sv
// Top level of the first-fit swap-area page allocator with compaction
`timescale 1ns / 1ps
// A request is taken when start_i is high and busy_o is low; results appear
// one per cycle on result_o, marked by result_valid_o for exactly one cycle,
// and must be captured then. The final result of a request has last set and
// goes out in the cycle in which busy_o falls. Read, write and finish scan the
// process table one entry per cycle. Start scans the hole table one entry per
// cycle; when compaction is needed it adds one pass to sum region sizes and
// one pass emitting a move per process. Configuration writes are taken only
// while busy_o is low; writing total_pages empties the process table and
// resets the hole table to one hole spanning the area (none if it is zero).
module first_fit_page_allocator_compacting
  import ffpa_pkg::*;
#(
  parameter int PROCESS_SLOTS   = 16,
  parameter int HOLE_SLOTS      = 32,
  parameter int PAGE_INDEX_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  req_t        req_i,
  output logic        busy_o,
  output logic        result_valid_o,
  output res_t        result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

`include "first_fit_page_allocator_compacting_macros.svh"

  cmd_t  cmd;
  stat_t stat;

  ffpa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (req_i.opcode),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  ffpa_dp #(
    .PROCESS_SLOTS   (PROCESS_SLOTS),
    .HOLE_SLOTS      (HOLE_SLOTS),
    .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  assign cfg_ready_o = !busy_o;

  `FFPA_ASSERT_NEXT(a_busy_after_start, start_i && !busy_o, busy_o, "not busy after start")
  `FFPA_ASSERT_SAME(a_move_while_busy, result_valid_o && result_o.kind == KIND_MOVE,
    busy_o && !result_o.last, "move command outside a request")
  `FFPA_ASSERT_SAME(a_done_with_reply, $fell(busy_o), result_valid_o && result_o.last,
    "request ended without final reply")

endmodule

>>> hw/rtl/ffpa_ctrl.sv
// Request sequencer of the page allocator
`timescale 1ns / 1ps
module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] opcode_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PSCAN = 4'd1;
  localparam logic [3:0] S_SCHK  = 4'd2;
  localparam logic [3:0] S_HSCAN = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_SPACE = 4'd5;
  localparam logic [3:0] S_MOVE  = 4'd6;
  localparam logic [3:0] S_ALLOC = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_REPLY = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = CMD_NONE;
    cmd_o.status  = ST_FAIL;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = CMD_LATCH;
          state_d  = (opcode_i == OP_START) ? S_SCHK : S_PSCAN;
        end
      end
      S_PSCAN: begin
        if (stat_i.proc_end) begin
          cmd_o.op = CMD_REPLY;
          state_d  = S_IDLE;
        end else if (stat_i.pid_hit) begin
          if (stat_i.opcode == OP_FINISH) begin
            cmd_o.op = CMD_LOAD;
            state_d  = S_MUL;
          end else if (stat_i.page_ok) begin
            cmd_o.op = CMD_RW_UPD;
            state_d  = S_MUL;
          end else begin
            cmd_o.op = CMD_REPLY;
            state_d  = S_IDLE;
          end
        end else begin
          cmd_o.op = CMD_NEXT;
        end
      end
      S_SCHK: begin
        if (stat_i.proc_full) begin
          cmd_o.op     = CMD_REPLY;
          cmd_o.status = ST_FULL;
          state_d      = S_IDLE;
        end else if (stat_i.arg_zero) begin
          cmd_o.op = CMD_REPLY;
          state_d  = S_IDLE;
        end else begin
          state_d = S_HSCAN;
        end
      end
      S_HSCAN: begin
        if (stat_i.hole_end) begin
          cmd_o.op = CMD_CLR;
          state_d  = S_SUM;
        end else if (stat_i.hole_fit) begin
          state_d = S_ALLOC;
        end else begin
          cmd_o.op = CMD_NEXT;
        end
      end
      S_SUM: begin
        if (stat_i.proc_end) begin
          state_d = S_SPACE;
        end else begin
          cmd_o.op = CMD_SUM;
        end
      end
      S_SPACE: begin
        if (!stat_i.space_ok) begin
          cmd_o.op = CMD_REPLY;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = CMD_CLR;
          state_d  = S_MOVE;
        end
      end
      S_MOVE: begin
        if (stat_i.proc_end) begin
          cmd_o.op = CMD_COMPACT;
          state_d  = S_ALLOC;
        end else begin
          cmd_o.op = CMD_MOVE;
        end
      end
      S_ALLOC: begin
        cmd_o.op = CMD_ALLOC;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = CMD_MUL;
        state_d  = S_REPLY;
      end
      S_REPLY: begin
        cmd_o.op     = CMD_REPLY;
        cmd_o.status = ST_OK;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> hw/rtl/ffpa_dp.sv
// Process and hole tables, scan index, address multiplier and result register
`timescale 1ns / 1ps
module ffpa_dp
  import ffpa_pkg::*;
#(
  parameter int PROCESS_SLOTS   = 16,
  parameter int HOLE_SLOTS      = 32,
  parameter int PAGE_INDEX_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        req_i,
  input  cmd_t        cmd_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  output stat_t       stat_o,
  output logic        result_valid_o,
  output res_t        result_o
);

  localparam int PCW = $clog2(PROCESS_SLOTS + 1);
  localparam int HCW = $clog2(HOLE_SLOTS + 1);
  localparam int IW  = (PCW > HCW) ? PCW : HCW;
  localparam int PIW = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int HIW = $clog2(HOLE_SLOTS);
  localparam int UW  = 13 + PCW;
  localparam logic [31:0] CAP = 32'd1 << PAGE_INDEX_BITS;
  localparam logic [12:0] RESET_AREA = (32'd4096 > CAP) ? CAP[12:0] : 13'd4096;

  function automatic logic [12:0] area_of(input logic [12:0] total);
    area_of = ({19'd0, total} > CAP) ? CAP[12:0] : total;
  endfunction

  logic [12:0] total_q;
  logic [16:0] pbytes_q;
  logic [PCW-1:0] pcnt_q;
  logic [HCW-1:0] hcnt_q;
  logic [15:0] pid_q    [PROCESS_SLOTS];
  logic [12:0] pstart_q [PROCESS_SLOTS];
  logic [12:0] psize_q  [PROCESS_SLOTS];
  logic [15:0] prd_q    [PROCESS_SLOTS];
  logic [15:0] pwr_q    [PROCESS_SLOTS];
  logic [12:0] hstart_q [HOLE_SLOTS];
  logic [12:0] hsize_q  [HOLE_SLOTS];
  logic [1:0]  op_q;
  logic [15:0] rpid_q;
  logic [12:0] arg_q;
  logic [IW-1:0] idx_q;
  logic [UW-1:0] used_q;
  logic [12:0] pos_q, start_q, size_q;
  logic [13:0] page_q;
  logic [15:0] rdc_q, wrc_q;
  logic [27:0] mul_q;
  logic [30:0] prod;
  res_t res_q, res_d;
  logic vld_q;

  logic [PIW-1:0] pi, pn;
  logic [HIW-1:0] hi, hn;
  logic [12:0] area, free_pages;
  logic [12:0] new_area;
  logic do_finish, hole_gone;

  assign pi = idx_q[PIW-1:0];
  assign hi = idx_q[HIW-1:0];
  assign pn = pcnt_q[PIW-1:0];
  assign hn = hcnt_q[HIW-1:0];
  assign area = area_of(total_q);
  assign new_area = area_of(cfg_data_i[12:0]);
  assign free_pages = (used_q > UW'(area)) ? 13'd0 : 13'(UW'(area) - used_q);
  assign prod = {17'd0, page_q} * {14'd0, pbytes_q};
  assign do_finish = (cmd_i.op == CMD_REPLY) && (cmd_i.status == ST_OK) &&
                     (op_q == OP_FINISH);
  assign hole_gone = (hsize_q[hi] == arg_q);

  assign stat_o.opcode    = op_q;
  assign stat_o.proc_end  = (IW'(pcnt_q) == idx_q);
  assign stat_o.hole_end  = (IW'(hcnt_q) == idx_q);
  assign stat_o.proc_full = (pcnt_q == PCW'(PROCESS_SLOTS));
  assign stat_o.arg_zero  = (arg_q == 13'd0);
  assign stat_o.pid_hit   = (pid_q[pi] == rpid_q);
  assign stat_o.page_ok   = (arg_q < psize_q[pi]);
  assign stat_o.hole_fit  = (hsize_q[hi] >= arg_q);
  assign stat_o.space_ok  = (arg_q <= free_pages);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_RW_UPD: begin
        if (op_q == OP_READ) begin
          if (prd_q[pi] != 16'hFFFF) prd_q[pi] <= prd_q[pi] + 16'd1;
        end else begin
          if (pwr_q[pi] != 16'hFFFF) pwr_q[pi] <= pwr_q[pi] + 16'd1;
        end
      end
      CMD_MOVE: begin
        pstart_q[pi] <= pos_q;
      end
      CMD_ALLOC: begin
        pid_q[pn]    <= rpid_q;
        pstart_q[pn] <= hstart_q[hi];
        psize_q[pn]  <= arg_q;
        prd_q[pn]    <= 16'd0;
        pwr_q[pn]    <= 16'd0;
      end
      CMD_REPLY: begin
        if (do_finish) begin
          for (int j = 0; j < PROCESS_SLOTS - 1; j++) begin
            if (PIW'(j) >= pi) begin
              pid_q[j]    <= pid_q[j+1];
              pstart_q[j] <= pstart_q[j+1];
              psize_q[j]  <= psize_q[j+1];
              prd_q[j]    <= prd_q[j+1];
              pwr_q[j]    <= pwr_q[j+1];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= 13'd4096;
      pbytes_q <= 17'd256;
      pcnt_q   <= '0;
      hcnt_q   <= HCW'((RESET_AREA != 13'd0) ? 1 : 0);
      for (int j = 0; j < HOLE_SLOTS; j++) begin
        hstart_q[j] <= 13'd0;
        hsize_q[j]  <= (j == 0) ? RESET_AREA : 13'd0;
      end
      idx_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_TOTAL_PAGES) begin
          total_q     <= cfg_data_i[12:0];
          pcnt_q      <= '0;
          hcnt_q      <= HCW'((new_area != 13'd0) ? 1 : 0);
          hstart_q[0] <= 13'd0;
          hsize_q[0]  <= new_area;
        end else if (cfg_index_i == CFG_PAGE_BYTES) begin
          pbytes_q <= cfg_data_i;
        end
      end
      case (cmd_i.op)
        CMD_LATCH, CMD_CLR: idx_q <= '0;
        CMD_NEXT, CMD_SUM, CMD_MOVE: idx_q <= idx_q + IW'(1);
        CMD_COMPACT: begin
          idx_q       <= '0;
          hcnt_q      <= HCW'(1);
          hstart_q[0] <= pos_q;
          hsize_q[0]  <= free_pages;
        end
        CMD_ALLOC: begin
          pcnt_q <= pcnt_q + PCW'(1);
          if (hole_gone) begin
            hcnt_q <= hcnt_q - HCW'(1);
            for (int j = 0; j < HOLE_SLOTS - 1; j++) begin
              if (HIW'(j) >= hi) begin
                hstart_q[j] <= hstart_q[j+1];
                hsize_q[j]  <= hsize_q[j+1];
              end
            end
          end else begin
            hstart_q[hi] <= hstart_q[hi] + arg_q;
            hsize_q[hi]  <= hsize_q[hi] - arg_q;
          end
        end
        CMD_REPLY: begin
          if (do_finish) begin
            pcnt_q <= pcnt_q - PCW'(1);
            if (hcnt_q < HCW'(HOLE_SLOTS) && size_q != 13'd0) begin
              hstart_q[hn] <= start_q;
              hsize_q[hn]  <= size_q;
              hcnt_q       <= hcnt_q + HCW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LATCH: begin
        op_q   <= req_i.opcode;
        rpid_q <= req_i.pid;
        arg_q  <= req_i.page_or_count;
        used_q <= '0;
      end
      CMD_CLR: pos_q <= 13'd0;
      CMD_SUM: used_q <= used_q + UW'(psize_q[pi]);
      CMD_MOVE: pos_q <= pos_q + psize_q[pi];
      CMD_LOAD: begin
        start_q <= pstart_q[pi];
        size_q  <= psize_q[pi];
        rdc_q   <= prd_q[pi];
        wrc_q   <= pwr_q[pi];
        page_q  <= {1'b0, pstart_q[pi]};
      end
      CMD_RW_UPD: begin
        start_q <= pstart_q[pi];
        page_q  <= {1'b0, pstart_q[pi]} + {1'b0, arg_q};
      end
      CMD_ALLOC: begin
        start_q <= hstart_q[hi];
        page_q  <= {1'b0, hstart_q[hi]};
      end
      CMD_MUL: mul_q <= prod[27:0];
      default: begin
      end
    endcase
  end

  always_comb begin
    res_d           = '0;
    res_d.reply_pid = rpid_q;
    res_d.status    = cmd_i.status;
    res_d.kind      = KIND_REPLY;
    res_d.last      = 1'b1;
    if (cmd_i.op == CMD_MOVE) begin
      res_d.kind           = KIND_MOVE;
      res_d.status         = ST_OK;
      res_d.reply_pid      = pid_q[pi];
      res_d.old_start_page = pstart_q[pi];
      res_d.new_start_page = pos_q;
      res_d.move_pages     = psize_q[pi];
      res_d.last           = 1'b0;
    end else if (cmd_i.status == ST_OK) begin
      res_d.byte_address = mul_q;
      case (op_q)
        OP_START: begin
          res_d.new_start_page = start_q;
          res_d.move_pages     = arg_q;
        end
        OP_FINISH: begin
          res_d.old_start_page = start_q;
          res_d.move_pages     = size_q;
          res_d.read_count     = rdc_q;
          res_d.write_count    = wrc_q;
        end
        default: res_d.new_start_page = start_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= (cmd_i.op == CMD_REPLY) || (cmd_i.op == CMD_MOVE);
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == CMD_REPLY) || (cmd_i.op == CMD_MOVE)) res_q <= res_d;
  end

  assign result_valid_o = vld_q;
  assign result_o       = res_q;

endmodule

>>> test/first_fit_page_allocator_compacting_test.sv
// Self-checking testbench for the first-fit page allocator with compaction
`timescale 1ns / 1ps
module first_fit_page_allocator_compacting_test;
  import ffpa_pkg::*;

  class alloc_scoreboard;
    bit [12:0] total_pages;
    bit [16:0] page_bytes;
    bit        p_valid[16];
    bit [15:0] p_id[16];
    bit [12:0] p_start[16];
    bit [12:0] p_size[16];
    bit [15:0] p_rd[16];
    bit [15:0] p_wr[16];
    bit        h_valid[32];
    bit [12:0] h_start[32];
    bit [12:0] h_size[32];
    res_t      pending[$];
    int        errors;

    function int area();
      return (total_pages > 4096) ? 4096 : total_pages;
    endfunction

    function void format_area();
      for (int i = 0; i < 16; i++) begin
        p_valid[i] = 0; p_id[i] = 0; p_start[i] = 0; p_size[i] = 0; p_rd[i] = 0; p_wr[i] = 0;
      end
      for (int i = 0; i < 32; i++) begin
        h_valid[i] = 0; h_start[i] = 0; h_size[i] = 0;
      end
      h_size[0] = 13'(area());
      h_valid[0] = (area() != 0);
    endfunction

    function void reset_state();
      total_pages = 13'd4096;
      page_bytes = 17'd256;
      errors = 0;
      format_area();
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] data);
      if (idx == CFG_TOTAL_PAGES) begin
        total_pages = data[12:0];
        format_area();
      end else if (idx == CFG_PAGE_BYTES) begin
        page_bytes = data;
      end
    endfunction

    function bit [27:0] byte_addr(int page);
      longint unsigned prod;
      prod = longint'(page) * longint'(page_bytes);
      return prod[27:0];
    endfunction

    function void push(logic kind, logic [1:0] st, logic [15:0] pid, logic [27:0] addr,
                       logic [12:0] olds, logic [12:0] news, logic [12:0] pages,
                       logic [15:0] rd, logic [15:0] wr, logic lst);
      res_t r;
      r.kind = kind; r.status = st; r.reply_pid = pid; r.byte_address = addr;
      r.old_start_page = olds; r.new_start_page = news; r.move_pages = pages;
      r.read_count = rd; r.write_count = wr; r.last = lst;
      pending.push_back(r);
    endfunction

    function int num_procs();
      int n;
      n = 0;
      while (n < 16 && p_valid[n]) n++;
      return n;
    endfunction

    function int num_holes();
      int n;
      n = 0;
      while (n < 32 && h_valid[n]) n++;
      return n;
    endfunction

    function int find_proc(logic [15:0] pid);
      for (int i = 0; i < 16; i++)
        if (p_valid[i] && p_id[i] == pid) return i;
      return -1;
    endfunction

    function void note(req_t q);
      int p, h, n, used, free_pages, pos;
      n = num_procs();
      case (q.opcode)
        OP_READ, OP_WRITE: begin
          p = find_proc(q.pid);
          if (p < 0 || q.page_or_count >= p_size[p]) begin
            push(KIND_REPLY, ST_FAIL, q.pid, 0, 0, 0, 0, 0, 0, 1);
          end else begin
            if (q.opcode == OP_READ) begin
              if (p_rd[p] != 16'hFFFF) p_rd[p]++;
            end else begin
              if (p_wr[p] != 16'hFFFF) p_wr[p]++;
            end
            push(KIND_REPLY, ST_OK, q.pid, byte_addr(p_start[p] + q.page_or_count), 0,
                 p_start[p], 0, 0, 0, 1);
          end
        end
        OP_FINISH: begin
          p = find_proc(q.pid);
          if (p < 0) begin
            push(KIND_REPLY, ST_FAIL, q.pid, 0, 0, 0, 0, 0, 0, 1);
          end else begin
            push(KIND_REPLY, ST_OK, q.pid, byte_addr(p_start[p]), p_start[p], 0,
                 p_size[p], p_rd[p], p_wr[p], 1);
            h = num_holes();
            if (h < 32 && p_size[p] != 0) begin
              h_valid[h] = 1; h_start[h] = p_start[p]; h_size[h] = p_size[p];
            end
            for (int j = p; j + 1 < n; j++) begin
              p_id[j] = p_id[j+1]; p_start[j] = p_start[j+1]; p_size[j] = p_size[j+1];
              p_rd[j] = p_rd[j+1]; p_wr[j] = p_wr[j+1];
            end
            if (n > 0) p_valid[n-1] = 0;
          end
        end
        default: begin
          if (n >= 16) begin
            push(KIND_REPLY, ST_FULL, q.pid, 0, 0, 0, 0, 0, 0, 1);
            return;
          end
          if (q.page_or_count == 0) begin
            push(KIND_REPLY, ST_FAIL, q.pid, 0, 0, 0, 0, 0, 0, 1);
            return;
          end
          h = -1;
          for (int i = 0; i < 32; i++)
            if (h < 0 && h_valid[i] && h_size[i] >= q.page_or_count) h = i;
          if (h < 0) begin
            used = 0;
            for (int i = 0; i < n; i++) used += p_size[i];
            free_pages = (used > area()) ? 0 : area() - used;
            if (q.page_or_count > free_pages) begin
              push(KIND_REPLY, ST_FAIL, q.pid, 0, 0, 0, 0, 0, 0, 1);
              return;
            end
            pos = 0;
            for (int i = 0; i < n; i++) begin
              push(KIND_MOVE, ST_OK, p_id[i], 0, p_start[i], 13'(pos), p_size[i], 0, 0, 0);
              p_start[i] = 13'(pos);
              pos += p_size[i];
            end
            for (int i = 0; i < 32; i++) begin
              h_valid[i] = 0; h_start[i] = 0; h_size[i] = 0;
            end
            h_valid[0] = 1; h_start[0] = 13'(pos); h_size[0] = 13'(free_pages);
            h = 0;
          end
          p_valid[n] = 1; p_id[n] = q.pid; p_start[n] = h_start[h];
          p_size[n] = q.page_or_count; p_rd[n] = 0; p_wr[n] = 0;
          h_start[h] += q.page_or_count;
          h_size[h] -= q.page_or_count;
          if (h_size[h] == 0) begin
            for (int j = h; j + 1 < num_holes(); j++) begin
              h_start[j] = h_start[j+1]; h_size[j] = h_size[j+1];
            end
            h_valid[num_holes() - 1] = 0;
          end
          push(KIND_REPLY, ST_OK, q.pid, byte_addr(p_start[n]), 0, p_start[n],
               q.page_or_count, 0, 0, 1);
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task cmp(string name, longint unsigned got, longint unsigned want);
      if (got != want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check(res_t got);
      res_t w;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing expected: %p", got));
        return;
      end
      w = pending.pop_front();
      cmp("kind", got.kind, w.kind);
      cmp("status", got.status, w.status);
      cmp("reply_pid", got.reply_pid, w.reply_pid);
      cmp("byte_address", got.byte_address, w.byte_address);
      cmp("old_start_page", got.old_start_page, w.old_start_page);
      cmp("new_start_page", got.new_start_page, w.new_start_page);
      cmp("move_pages", got.move_pages, w.move_pages);
      cmp("read_count", got.read_count, w.read_count);
      cmp("write_count", got.write_count, w.write_count);
      cmp("last", got.last, w.last);
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  req_t        req_i = '0;
  logic        busy_o;
  logic        result_valid_o;
  res_t        result_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;

  alloc_scoreboard sb = new();
  bit          idle_on = 1;
  int          stall_cycles = 0;
  int          n_items = 0;
  int          n_moves = 0;
  logic [15:0] pid_pool[6] = '{16'h0000, 16'h0001, 16'h00A5, 16'h8000, 16'hFFFF, 16'h1234};

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  first_fit_page_allocator_compacting dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i), .busy_o(busy_o),
    .result_valid_o(result_valid_o), .result_o(result_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_cycles++;
      if (result_valid_o) begin
        sb.check(result_o);
        if (result_o.kind == KIND_MOVE) n_moves++;
        stall_cycles = 0;
      end
      if (start_i && !busy_o) begin
        sb.note(req_i);
        n_items++;
        stall_cycles = 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_reg(cfg_index_i, cfg_data_i);
        stall_cycles = 0;
      end
      if (stall_cycles > 5000) begin
        $display("timeout: no transaction for 5000 cycles");
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task send(logic [1:0] op, logic [15:0] pid, logic [12:0] arg);
    if (idle_on && $urandom_range(99) < 33) repeat ($urandom_range(1, 5)) @(negedge clk_i);
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    start_i = 1;
    req_i.opcode = op; req_i.pid = pid; req_i.page_or_count = arg;
    @(negedge clk_i);
    start_i = 0;
    req_i = req_t'(31'($urandom));
  endtask

  task drain();
    @(negedge clk_i);
    while (sb.pending.size() != 0 || busy_o) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task write_cfg(logic [1:0] idx, logic [16:0] data);
    drain();
    while (!cfg_ready_o) @(negedge clk_i);
    cfg_valid_i = 1; cfg_index_i = idx; cfg_data_i = data;
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task send_random(int area_now);
    logic [1:0]  op;
    logic [15:0] pid;
    logic [12:0] arg;
    int          r;
    int          top;
    r = $urandom_range(99);
    op = (r < 35) ? OP_START : (r < 55) ? OP_FINISH : (r < 77) ? OP_READ : OP_WRITE;
    pid = ($urandom_range(9) == 0) ? 16'($urandom) : pid_pool[$urandom_range(0, 5)];
    r = $urandom_range(99);
    top = (area_now / 6 > 1) ? area_now / 6 : 1;
    if (op == OP_START)
      arg = (r < 85) ? 13'($urandom_range(1, top)) : (r < 95) ? 13'($urandom_range(0, 4096)) : 13'd0;
    else
      arg = (r < 80) ? 13'($urandom_range(0, 7)) : 13'($urandom_range(0, 4096));
    send(op, pid, arg);
  endtask

  initial begin
    int tp[5] = '{64, 8, 4096, 1, 200};
    int pb[5];
    pb[0] = 1; pb[1] = 65536; pb[2] = $urandom_range(1, 65536); pb[3] = 3;
    pb[4] = $urandom_range(1, 65536);
    sb.reset_state();
    req_i = req_t'(31'($urandom));
    repeat (10) @(negedge clk_i);
    rst_ni = 1;

    send(OP_READ, 16'd5, 13'd0);
    send(OP_FINISH, 16'd5, 13'd0);
    send(OP_START, 16'd5, 13'd0);
    send(OP_START, 16'hFFFF, 13'd4096);
    send(OP_START, 16'd1, 13'd1);
    send(OP_READ, 16'hFFFF, 13'd4095);
    send(OP_WRITE, 16'hFFFF, 13'd4096);
    send(OP_WRITE, 16'hFFFF, 13'd0);
    send(OP_FINISH, 16'hFFFF, 13'd0);

    write_cfg(CFG_TOTAL_PAGES, 17'd64);
    send(OP_START, 16'd10, 13'd16);
    send(OP_START, 16'd11, 13'd16);
    send(OP_START, 16'd10, 13'd16);
    send(OP_START, 16'd13, 13'd16);
    send(OP_READ, 16'd10, 13'd15);
    send(OP_FINISH, 16'd11, 13'd0);
    send(OP_FINISH, 16'd13, 13'd0);
    send(OP_START, 16'd14, 13'd32);
    send(OP_READ, 16'd10, 13'd3);

    write_cfg(CFG_TOTAL_PAGES, 17'd4096);
    for (int i = 0; i < 16; i++) send(OP_START, 16'(100 + i), 13'd2);
    send(OP_START, 16'd200, 13'd1);
    for (int i = 0; i < 16; i++) send(OP_FINISH, 16'(100 + i), 13'd0);
    for (int i = 0; i < 16; i++) send(OP_START, 16'(300 + i), 13'd1);
    for (int i = 0; i < 16; i++) send(OP_FINISH, 16'(300 + i), 13'd0);
    send(OP_START, 16'd400, 13'd4090);

    write_cfg(CFG_TOTAL_PAGES, 17'd4096);
    idle_on = 0;
    send(OP_START, 16'd7, 13'd1);
    for (int i = 0; i < 4; i++) send(OP_READ, 16'd7, 13'd0);
    for (int i = 0; i < 4; i++) send(OP_WRITE, 16'd7, 13'd0);
    send(OP_FINISH, 16'd7, 13'd0);

    for (int ph = 0; ph < 5; ph++) begin
      idle_on = (ph != 2);
      write_cfg(CFG_TOTAL_PAGES, 17'(tp[ph]));
      write_cfg(CFG_PAGE_BYTES, 17'(pb[ph]));
      for (int i = 0; i < 28; i++) send_random(tp[ph]);
    end

    drain();
    $display("covered %0d requests over five area sizes, %0d compaction moves",
             n_items, n_moves);
    $display("including table full, hole table overflow and forced compaction");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ffpa_pkg.sv
hw/rtl/ffpa_ctrl.sv
hw/rtl/ffpa_dp.sv
hw/rtl/first_fit_page_allocator_compacting.sv
test/first_fit_page_allocator_compacting_test.sv
